### hdl/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the sorted table: sizes, operation and
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int POS_W = 6;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LOAD_TOP,
    PTR_LOAD_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    WA_UP,
    WA_DOWN,
    WA_ZERO
  } waddr_t;

  typedef enum logic {
    WD_NEW,
    WD_RDATA
  } wdata_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_FIRST,
    S_INS_STEP,
    S_INS_LAST,
    S_DEL_FIRST,
    S_DEL_TAKE,
    S_DEL_SHIFT,
    S_RD_FIRST,
    S_RD_TAKE
  } state_t;

  typedef struct packed {
    logic    capture;
    ptr_op_t ptr_op;
    logic    mem_rd;
    logic    wr_en;
    waddr_t  wr_addr_sel;
    wdata_t  wr_data_sel;
    logic    take_entry;
    logic    respond;
    status_t status;
    cnt_op_t cnt_op;
  } sti_cmd_t;

  typedef struct packed {
    func_t func;
    logic  full;
    logic  cnt_zero;
    logic  pos_ok;
    logic  key_ge;
    logic  prev_zero;
    logic  more;
  } sti_sts_t;

endpackage

### hdl/sti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_datapath
// Entry memory, transaction registers, walk pointers, entry count and the
// registered result.
// ----------------------------------------------------------------------------
module sti_datapath
  import sti_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_func,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0]        in_tag,
  input  logic [POS_W-1:0]        in_position,
  input  sti_cmd_t                cmd,
  output sti_sts_t                sts,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic [TAG_W-1:0]        out_tag_out,
  output logic [CNT_W-1:0]        out_count
);

  logic [KEY_W-1:0]        key_mem [DEPTH];
  logic [TAG_W-1:0]        tag_mem [DEPTH];

  func_t                   func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [TAG_W-1:0]        tag_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        prev_r;
  logic signed [KEY_W-1:0] rkey_r;
  logic [TAG_W-1:0]        rtag_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [KEY_W-1:0]        out_key_r;
  logic [TAG_W-1:0]        out_tag_r;

  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_W-1:0]        wr_key;
  logic [TAG_W-1:0]        wr_tag;

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      key_r  <= in_key;
      tag_r  <= in_tag;
      pos_r  <= in_position;
    end
  end

  // walk pointer
  always_ff @(posedge clk) begin
    case (cmd.ptr_op)
      PTR_LOAD_TOP: ptr_r <= count_r - CNT_W'(1);
      PTR_LOAD_POS: ptr_r <= CNT_W'(CMP_W'(pos_r) - CMP_W'(1));
      PTR_INC:      ptr_r <= ptr_r + CNT_W'(1);
      PTR_DEC:      ptr_r <= ptr_r - CNT_W'(1);
      default:      ptr_r <= ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_addr_sel)
      WA_UP:   wr_addr = IDX_W'(prev_r + CNT_W'(1));
      WA_DOWN: wr_addr = IDX_W'(prev_r - CNT_W'(1));
      default: wr_addr = '0;
    endcase
    case (cmd.wr_data_sel)
      WD_RDATA: begin
        wr_key = rkey_r;
        wr_tag = rtag_r;
      end
      default: begin
        wr_key = key_r;
        wr_tag = tag_r;
      end
    endcase
  end

  // single read port, single write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
    if (cmd.mem_rd) begin
      rkey_r <= key_mem[ptr_r[IDX_W-1:0]];
      rtag_r <= tag_mem[ptr_r[IDX_W-1:0]];
      prev_r <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
      case (cmd.cnt_op)
        CNT_INC: count_r <= count_r + CNT_W'(1);
        CNT_DEC: count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_status_r <= cmd.status;
    end
    if (cmd.capture) begin
      out_key_r <= '0;
      out_tag_r <= '0;
    end else if (cmd.take_entry) begin
      out_key_r <= rkey_r;
      out_tag_r <= rtag_r;
    end
  end

  always_comb begin
    sts.func      = func_r;
    sts.full      = (count_r == CNT_W'(DEPTH));
    sts.cnt_zero  = (count_r == '0);
    sts.pos_ok    = (pos_r != '0) && (CMP_W'(pos_r) <= CMP_W'(count_r));
    sts.key_ge    = (rkey_r >= key_r);
    sts.prev_zero = (prev_r == '0);
    sts.more      = (ptr_r < count_r);
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;
  assign out_tag_out = out_tag_r;
  assign out_count   = count_r;

endmodule

### hdl/sti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_ctrl
// Controller for the sorted table: dispatches a transaction and steps the
// datapath through the scan and shift of the entry memory.
// ----------------------------------------------------------------------------
module sti_ctrl
  import sti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sti_sts_t sts,
  output sti_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.func)
          FUNC_INSERT: begin
            if (sts.full)          state_nxt = S_IDLE;
            else if (sts.cnt_zero) state_nxt = S_INS_LAST;
            else                   state_nxt = S_INS_FIRST;
          end
          FUNC_DELETE: state_nxt = sts.pos_ok ? S_DEL_FIRST : S_IDLE;
          FUNC_READ:   state_nxt = sts.pos_ok ? S_RD_FIRST : S_IDLE;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_INS_FIRST: state_nxt = S_INS_STEP;
      S_INS_STEP: begin
        if (!sts.key_ge)        state_nxt = S_IDLE;
        else if (sts.prev_zero) state_nxt = S_INS_LAST;
      end
      S_INS_LAST:  state_nxt = S_IDLE;
      S_DEL_FIRST: state_nxt = S_DEL_TAKE;
      S_DEL_TAKE:  state_nxt = sts.more ? S_DEL_SHIFT : S_IDLE;
      S_DEL_SHIFT: begin
        if (!sts.more) state_nxt = S_IDLE;
      end
      S_RD_FIRST:  state_nxt = S_RD_TAKE;
      S_RD_TAKE:   state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.capture     = 1'b0;
    cmd.ptr_op      = PTR_HOLD;
    cmd.mem_rd      = 1'b0;
    cmd.wr_en       = 1'b0;
    cmd.wr_addr_sel = WA_UP;
    cmd.wr_data_sel = WD_NEW;
    cmd.take_entry  = 1'b0;
    cmd.respond     = 1'b0;
    cmd.status      = ST_OK;
    cmd.cnt_op      = CNT_HOLD;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_DISPATCH: begin
        case (sts.func)
          FUNC_INSERT: begin
            if (sts.full) begin
              cmd.respond = 1'b1;
              cmd.status  = ST_FULL;
            end else if (!sts.cnt_zero) begin
              cmd.ptr_op = PTR_LOAD_TOP;
            end
          end
          FUNC_DELETE, FUNC_READ: begin
            if (sts.pos_ok) begin
              cmd.ptr_op = PTR_LOAD_POS;
            end else begin
              cmd.respond = 1'b1;
              cmd.status  = ST_BAD;
            end
          end
          default: begin
            cmd.respond = 1'b1;
          end
        endcase
      end
      S_INS_FIRST: begin
        cmd.mem_rd = 1'b1;
        cmd.ptr_op = PTR_DEC;
      end
      S_INS_STEP: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_UP;
        if (sts.key_ge) begin
          cmd.wr_data_sel = WD_RDATA;
          if (!sts.prev_zero) begin
            cmd.mem_rd = 1'b1;
            cmd.ptr_op = PTR_DEC;
          end
        end else begin
          cmd.wr_data_sel = WD_NEW;
          cmd.respond     = 1'b1;
          cmd.cnt_op      = CNT_INC;
        end
      end
      S_INS_LAST: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_data_sel = WD_NEW;
        cmd.respond     = 1'b1;
        cmd.cnt_op      = CNT_INC;
      end
      S_DEL_FIRST, S_RD_FIRST: begin
        cmd.mem_rd = 1'b1;
        cmd.ptr_op = PTR_INC;
      end
      S_DEL_TAKE: begin
        cmd.take_entry = 1'b1;
        if (sts.more) begin
          cmd.mem_rd = 1'b1;
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.respond = 1'b1;
          cmd.cnt_op  = CNT_DEC;
        end
      end
      S_DEL_SHIFT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_DOWN;
        cmd.wr_data_sel = WD_RDATA;
        if (sts.more) begin
          cmd.mem_rd = 1'b1;
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.respond = 1'b1;
          cmd.cnt_op  = CNT_DEC;
        end
      end
      S_RD_TAKE: begin
        cmd.take_entry = 1'b1;
        cmd.respond    = 1'b1;
      end
      default: begin
        cmd.capture = 1'b0;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hdl/sorted_table_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_delete
// Sorted table of up to DEPTH (key, tag) entries with insert, delete at
// position and read at position, one result per transaction.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result
// appears on the out_ ports for exactly one cycle, marked by out_valid, in
// the cycle after busy falls; there is no way to hold it off, so capture it
// then. On a delete busy lasts longer the more entries lie past the position,
// and on an insert into a non-empty table the more entries have a key that is
// not smaller than the new key. The length is set by the entry memory, which
// has one read and one write port and so moves one entry per cycle while the
// table is opened up or closed. A new start can be taken in the cycle that
// shows the previous result. out_count always shows the current entry count.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete
  import sti_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0]        in_tag,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic [TAG_W-1:0]        out_tag_out,
  output logic [CNT_W-1:0]        out_count
);

  // command and status bundles between controller and datapath
  sti_cmd_t cmd;
  sti_sts_t sts;

  // controller: dispatch, then scan/shift one entry per cycle
  sti_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: entry memory, pointers, count and result registers
  sti_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_func),
    .in_key      (in_key),
    .in_tag      (in_tag),
    .in_position (in_position),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_tag_out (out_tag_out),
    .out_count   (out_count)
  );

`ifndef SYNTHESIS
  // count never goes past the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_count <= CNT_W'(DEPTH))
    else $error("entry count beyond table size");

  // every result marks the end of a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe without a finished transaction");

  // every busy period ends in exactly one result
  a_busy_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction finished without a result");

  // a full report only when the table is full
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == CNT_W'(DEPTH)))
    else $error("full reported with room left");

  // an error result carries no entry
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD) |-> (out_key_out == '0 && out_tag_out == '0))
    else $error("error result carries entry data");
`endif

endmodule
